@@ rtl/uafl_pkg.sv @@
// uafl_pkg: shared types, byte constants and the accent fold table for the
// UTF-8 accent fold / lowercase block. Used by the fold logic and the top level.
// No dependencies.
package uafl_pkg;

  // Byte constants
  localparam logic [7:0] LEAD_BYTE   = 8'hC3;  // lead byte of the Latin-1 accented range
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_TAG    = 8'h80;  // continuation byte pattern 10xxxxxx
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] UPPER_A     = 8'h41;
  localparam logic [7:0] UPPER_Z     = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;  // 'a' - 'A'
  localparam logic [7:0] NO_FOLD     = 8'h00;

  // Outcome of one input word, handed from the fold logic to the control path
  typedef struct packed {
    logic [1:0] n_res;     // results caused by this word: 0, 1 or 2
    logic [7:0] byte0;     // first result byte
    logic [7:0] byte1;     // second result byte, valid when n_res is 2
    logic       lead_nxt;  // lead byte held after this word
  } fold_res_t;

  // Plain lower-case letter for a second byte, indexed by its low five bits.
  // Upper and lower case accented letters share the same low bits.
  function automatic logic [7:0] fold_letter(input logic [4:0] idx);
    logic [7:0] letter;
    unique case (idx)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4:         letter = 8'h61;  // a
      5'd7:                                 letter = 8'h63;  // c
      5'd8, 5'd9, 5'd10:                    letter = 8'h65;  // e
      5'd12, 5'd13, 5'd14:                  letter = 8'h69;  // i
      5'd18, 5'd19, 5'd20, 5'd21, 5'd22:    letter = 8'h6F;  // o
      5'd25, 5'd26, 5'd27:                  letter = 8'h75;  // u
      default:                              letter = NO_FOLD;
    endcase
    return letter;
  endfunction

endpackage

@@ rtl/uafl_in_if.sv @@
// uafl_in_if: input channel of the accent fold block, one source byte per word.
// Depends on nothing.
interface uafl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

@@ rtl/uafl_out_if.sv @@
// uafl_out_if: result channel of the accent fold block, one folded byte per word.
// Depends on nothing.
interface uafl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_item;
  logic       string_done;

  modport source (output valid, output out_byte, output last_of_item, output string_done,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_item, input string_done,
                  output ready);
endinterface

@@ rtl/uafl_fold.sv @@
// uafl_fold: combinational fold of one source byte given the held lead state.
// Depends on uafl_pkg (constants, fold table, fold_res_t).
module uafl_fold (
  input  logic                 lead_pending,
  input  logic [7:0]           src_byte,
  input  logic                 src_end,
  output uafl_pkg::fold_res_t  res
);

  logic [7:0] letter;
  logic       hit;
  logic [7:0] fresh_byte;
  logic       fresh_emit;

  // Second byte of a held lead folds when it is a table continuation byte
  assign letter = uafl_pkg::fold_letter(src_byte[4:0]);
  assign hit    = ((src_byte & uafl_pkg::CONT_MASK) == uafl_pkg::CONT_TAG) &&
                  (letter != uafl_pkg::NO_FOLD);

  // Byte handled with no lead held: ASCII capitals lowered, a lead is held
  // unless it ends the string, anything else copied
  always_comb begin
    fresh_byte = src_byte;
    if (src_byte < uafl_pkg::ASCII_LIMIT && src_byte >= uafl_pkg::UPPER_A &&
        src_byte <= uafl_pkg::UPPER_Z) begin
      fresh_byte = src_byte + uafl_pkg::CASE_OFFSET;
    end
  end
  assign fresh_emit = (src_byte != uafl_pkg::LEAD_BYTE) || src_end;

  // Assemble the result list
  always_comb begin
    res.byte1 = fresh_byte;
    if (lead_pending && hit) begin
      res.n_res = 2'd1;
      res.byte0 = letter;
    end else if (lead_pending) begin
      res.n_res = fresh_emit ? 2'd2 : 2'd1;
      res.byte0 = uafl_pkg::LEAD_BYTE;
    end else begin
      res.n_res = fresh_emit ? 2'd1 : 2'd0;
      res.byte0 = fresh_byte;
    end
    res.lead_nxt = !src_end && (src_byte == uafl_pkg::LEAD_BYTE);
  end

endmodule

@@ rtl/utf8_accent_fold_lowercase.sv @@
// utf8_accent_fold_lowercase: top level, input stage, lead state, output register.
// Depends on uafl_pkg, uafl_in_if, uafl_out_if and uafl_fold.
//
// Usage:
//   in_ch carries one UTF-8 source byte per word with string_end on the last
//   byte of a string. out_ch carries the folded bytes; last_of_item marks the
//   last result caused by an input byte, string_done the final byte of a string.
//   Both channels use valid/ready; a word moves when both are high.
//   Path: a byte taken is held in the input stage, folded combinationally, and
//   its first result goes to the output register (two registers: input stage, output register).
//   Throughput: one input byte per cycle while each byte yields at most one
//   result and out_ch.ready stays high. A byte that yields two results (a held
//   0xC3 that does not fold, followed by a byte that is emitted) holds the input
//   stage until both are sent, since the single output register takes one result
//   per cycle. A 0xC3 that is held produces no result and leaves the stage without waiting on out_ch.
//   Reset (rst_n low, synchronous) empties both stages and drops any held lead.
//   When out_ch.ready is low the output word holds; a staged word that still
//   has a result to send stays put and in_ch.ready is low in that same cycle,
//   so no word is lost.
module utf8_accent_fold_lowercase (
  input  logic              clk,
  input  logic              rst_n,
  uafl_in_if.sink           in_ch,
  uafl_out_if.source        out_ch
);

  // Input stage
  logic       stage_valid_r;
  logic [7:0] stage_byte_r;
  logic       stage_end_r;
  logic       phase_r;    // second result of the staged word is next
  logic       lead_r;     // lead byte held from an earlier word

  // Output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_done_r;

  uafl_pkg::fold_res_t res;
  logic       out_free;
  logic       emit;
  logic       is_last;
  logic       retire;
  logic       in_take;
  logic [7:0] sel_byte;

  uafl_fold u_fold (
    .lead_pending (lead_r),
    .src_byte     (stage_byte_r),
    .src_end      (stage_end_r),
    .res          (res)
  );

  // Handshake and stage control
  assign out_free = !out_valid_r || out_ch.ready;
  assign is_last  = phase_r || (res.n_res == 2'd1);
  assign emit     = stage_valid_r && (res.n_res != 2'd0) && out_free;
  assign retire   = stage_valid_r && ((res.n_res == 2'd0) || (out_free && is_last));
  assign sel_byte = phase_r ? res.byte1 : res.byte0;

  assign in_ch.ready = !stage_valid_r || retire;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Input stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      phase_r       <= 1'b0;
      lead_r        <= 1'b0;
    end else begin
      if (in_take) begin
        stage_valid_r <= 1'b1;
      end else if (retire) begin
        stage_valid_r <= 1'b0;
      end
      if (retire) begin
        phase_r <= 1'b0;
        lead_r  <= res.lead_nxt;
      end else if (emit) begin
        phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_byte_r <= in_ch.in_byte;
      stage_end_r  <= in_ch.string_end;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= sel_byte;
      out_last_r <= is_last;
      out_done_r <= is_last && stage_end_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.last_of_item = out_last_r;
  assign out_ch.string_done  = out_done_r;

  // Checks
  a_end_clears_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (retire && stage_end_r) |=> !lead_r)
    else $error("lead still held after end of string");

  a_phase_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (stage_valid_r && res.n_res == 2'd2))
    else $error("second result pending without a two-result word");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_done_r || out_last_r))
    else $error("string_done on a result that is not last of its word");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid_r && !retire) |-> !in_take)
    else $error("input word taken while stage is occupied");

endmodule
